### rtl/hnct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hnct_pkg;

	localparam int MAX_NOTES = 12;
	localparam int IDX_W     = $clog2(MAX_NOTES);
	localparam int CNT_W     = 4;

	// operation codes on s_tuser
	localparam logic [1:0] OP_MIDI  = 2'd0;
	localparam logic [1:0] OP_PURGE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [4:0] CHANNEL_ALL  = 5'd16;

	// decoded command held for the whole walk
	localparam logic [2:0] CMD_NONE  = 3'd0;
	localparam logic [2:0] CMD_ON    = 3'd1;
	localparam logic [2:0] CMD_OFF   = 3'd2;
	localparam logic [2:0] CMD_PURGE = 3'd3;
	localparam logic [2:0] CMD_READ  = 3'd4;

	typedef logic [2:0] cmd_t;

	typedef struct packed {
		logic       held;
		logic [6:0] vel;
		logic [6:0] note;
	} entry_t;

	typedef struct packed {
		logic   keep;
		entry_t ent;
		logic   inc;
		logic   dec;
		logic   hit;
		logic   chg;
	} unit_res_t;

	typedef struct packed {
		logic             entry_valid;
		entry_t           ent;
		logic [CNT_W-1:0] len;
		logic [CNT_W-1:0] held;
		logic             chg;
		logic             last;
	} out_res_t;

endpackage

`default_nettype wire

### rtl/hnct_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module hnct_unit (
	input  hnct_pkg::cmd_t    cmd,
	input  hnct_pkg::entry_t  entry,
	input  logic [6:0]        note,
	input  logic [6:0]        vel,
	input  logic              hold,
	input  logic              found,
	output hnct_pkg::unit_res_t res
);
	import hnct_pkg::*;

	logic hit;

	assign hit = (entry.note == note);

	always_comb begin
		res      = '0;
		res.keep = 1'b1;
		res.ent  = entry;
		unique case (cmd)
			CMD_ON: begin
				// only the first match is refreshed
				if (hit && !found) begin
					res.ent.vel  = vel;
					res.ent.held = 1'b1;
					res.inc      = !entry.held;
					res.hit      = 1'b1;
				end
			end
			CMD_OFF: begin
				if (hit) begin
					if (hold) begin
						res.ent.held = 1'b0;
						res.dec      = entry.held;
					end else begin
						res.keep = 1'b0;
						res.dec  = 1'b1;
						res.chg  = 1'b1;
					end
				end
			end
			CMD_PURGE: begin
				res.keep = entry.held;
				res.chg  = !entry.held;
			end
			default: begin
				res.keep = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/hnct_out.sv
`timescale 1ns / 1ps
`default_nettype none

module hnct_out (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hnct_pkg::out_res_t res,
	output logic               free,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,  // entry_note, entry_velocity, entry_held,
	                                     // chord_length, held_count, changed
	output logic [0:0]         m_tuser,  // entry_valid
	output logic               m_tlast
);
	import hnct_pkg::*;

	logic     vld_q;
	out_res_t res_q;

	assign free = !vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = {res_q.chg, res_q.held, res_q.len, res_q.ent.held,
	                   res_q.ent.vel, res_q.ent.note};
	assign m_tuser  = res_q.entry_valid;
	assign m_tlast  = res_q.last;

endmodule

`default_nettype wire

### rtl/held_note_chord_table_top.sv
`timescale 1ns / 1ps
`default_nettype none

// held note chord table
// s_* takes one word per item: s_tuser is the operation (midi message, hold
// release purge, read), s_tdata the midi status, note, velocity and hold mark.
// m_* returns result words; m_tlast marks the final word of an item. a read
// returns one word per table entry (m_tuser high), or one status word with
// m_tuser low when the table is empty; every other operation returns one
// status word. cfg_* writes the midi channel filter (16 = omni); it is always
// ready and is meant to be written while the block is idle.
// a midi or purge item is decoded in the idle state, then each table entry
// (0 to 12) passes through the shared entry unit in the scan state, a new note
// is appended in the append state, and the emit state loads the output
// register. a read walks the table at one word per cycle; a stalled receiver
// holds the walk at the current entry. s_tready is high only while the
// sequencer is idle; the output register lets the next item be taken while
// the last word still waits. reset empties the table, clears counters and the
// changed flag, sets omni and drops any pending output word.
module held_note_chord_table_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // status_byte, note_number, velocity, hold_active
	input  wire  [1:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // entry_note, entry_velocity, entry_held,
	                               // chord_length, held_count, changed
	output logic [0:0]  m_tuser,   // entry_valid
	output logic        m_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [4:0]  cfg_data
);
	import hnct_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_APPEND = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_READ   = 3'd4;

	logic [2:0]       st_q;
	logic [4:0]       chan_q;
	cmd_t             cmd_q;
	logic [6:0]       note_q;
	logic [6:0]       vel_q;
	logic             hold_q;
	logic [IDX_W-1:0] rd_q;
	logic [IDX_W-1:0] wr_q;
	logic             found_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] held_q;
	logic             changed_q;
	logic             rdchg_q;
	entry_t           tbl_q [MAX_NOTES];

	logic             accept;
	logic [7:0]       in_status;
	logic [6:0]       in_note;
	logic [6:0]       in_vel;
	logic             in_hold;
	logic             chan_pass;
	cmd_t             in_cmd;
	entry_t           rd_entry;
	logic [IDX_W-1:0] rd_inc;
	logic             rd_last;
	unit_res_t        ures;
	logic             tbl_we;
	logic [IDX_W-1:0] tbl_wa;
	entry_t           tbl_wd;
	logic             out_free;
	logic             out_load;
	out_res_t         ores;
	logic [CNT_W-1:0] held_dec;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;

	assign in_status = s_tdata[7:0];
	assign in_note   = s_tdata[14:8];
	assign in_vel    = s_tdata[21:15];
	assign in_hold   = s_tdata[22];

	assign chan_pass = (chan_q == CHANNEL_ALL) || ({1'b0, in_status[3:0]} == chan_q);

	always_comb begin
		in_cmd = CMD_NONE;
		priority if (s_tuser == OP_READ) begin
			in_cmd = CMD_READ;
		end else if (s_tuser == OP_PURGE) begin
			in_cmd = CMD_PURGE;
		end else if (s_tuser == OP_MIDI && chan_pass) begin
			if (in_status[7:4] == NIB_NOTE_ON && in_vel != 7'd0) begin
				in_cmd = CMD_ON;
			end else if (in_status[7:4] == NIB_NOTE_ON || in_status[7:4] == NIB_NOTE_OFF) begin
				in_cmd = CMD_OFF;
			end
		end else begin
			in_cmd = CMD_NONE;
		end
	end

	assign rd_entry = tbl_q[rd_q];
	assign rd_inc   = rd_q + IDX_W'(1);
	assign rd_last  = (CNT_W'(rd_inc) == len_q);
	assign held_dec = (held_q != '0) ? held_q - CNT_W'(1) : held_q;

	hnct_unit u_unit (
		.cmd   (cmd_q),
		.entry (rd_entry),
		.note  (note_q),
		.vel   (vel_q),
		.hold  (hold_q),
		.found (found_q),
		.res   (ures)
	);

	// table write port: compaction during the walk, or the append
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = wr_q;
		tbl_wd = ures.ent;
		if (st_q == ST_SCAN) begin
			tbl_we = ures.keep;
		end else if (st_q == ST_APPEND) begin
			tbl_we = (len_q < CNT_W'(MAX_NOTES));
			tbl_wa = len_q[IDX_W-1:0];
			tbl_wd = '{held: 1'b1, vel: vel_q, note: note_q};
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_q[tbl_wa] <= tbl_wd;
		end
	end

	always_comb begin
		ores             = '0;
		ores.entry_valid = (st_q == ST_READ);
		ores.ent         = (st_q == ST_READ) ? rd_entry : '0;
		ores.len         = len_q;
		ores.held        = held_q;
		ores.chg         = (cmd_q == CMD_READ) ? rdchg_q : changed_q;
		ores.last        = (st_q == ST_EMIT) || rd_last;
	end

	assign out_load = out_free && ((st_q == ST_EMIT) || (st_q == ST_READ));

	hnct_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (out_load),
		.res      (ores),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			chan_q    <= CHANNEL_ALL;
			cmd_q     <= CMD_NONE;
			note_q    <= '0;
			vel_q     <= '0;
			hold_q    <= 1'b0;
			rd_q      <= '0;
			wr_q      <= '0;
			found_q   <= 1'b0;
			len_q     <= '0;
			held_q    <= '0;
			changed_q <= 1'b0;
			rdchg_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				chan_q <= cfg_data;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						note_q  <= in_note;
						vel_q   <= in_vel;
						hold_q  <= in_hold;
						rd_q    <= '0;
						wr_q    <= '0;
						found_q <= 1'b0;
						unique case (in_cmd)
							CMD_READ: begin
								rdchg_q   <= changed_q;
								changed_q <= 1'b0;
								st_q      <= (len_q == '0) ? ST_EMIT : ST_READ;
							end
							CMD_ON: begin
								changed_q <= 1'b1;
								// nothing held: a new chord starts
								if (held_q == '0) begin
									len_q <= '0;
									st_q  <= ST_APPEND;
								end else begin
									st_q <= (len_q == '0) ? ST_APPEND : ST_SCAN;
								end
							end
							CMD_OFF, CMD_PURGE: begin
								st_q <= (len_q == '0) ? ST_EMIT : ST_SCAN;
							end
							default: begin
								st_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_q <= rd_inc;
					if (ures.keep) begin
						wr_q <= wr_q + IDX_W'(1);
					end
					if (ures.inc) begin
						held_q <= held_q + CNT_W'(1);
					end else if (ures.dec) begin
						held_q <= held_dec;
					end
					if (ures.chg) begin
						changed_q <= 1'b1;
					end
					if (ures.hit) begin
						found_q <= 1'b1;
					end
					if (rd_last) begin
						len_q <= CNT_W'(wr_q) + CNT_W'(ures.keep);
						st_q  <= (cmd_q == CMD_ON && !found_q && !ures.hit) ?
						         ST_APPEND : ST_EMIT;
					end
				end
				ST_APPEND: begin
					if (len_q < CNT_W'(MAX_NOTES)) begin
						len_q  <= len_q + CNT_W'(1);
						held_q <= held_q + CNT_W'(1);
					end
					st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				ST_READ: begin
					if (out_free) begin
						rd_q <= rd_inc;
						if (rd_last) begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(MAX_NOTES))
		else $error("chord length above table depth");

	a_held_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= len_q)
		else $error("held count exceeds chord length");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SCAN || st_q == ST_READ) |-> (CNT_W'(rd_q) < len_q))
		else $error("walk index beyond chord length");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == OP_READ) |=> !changed_q)
		else $error("read did not clear changed flag");
`endif

endmodule

`default_nettype wire
